[rtl/fpct_pkg.sv]
// ---------------------------------------------------------------------------
// fpct_pkg
// Shared types and constants for the fault point countdown table.
// ---------------------------------------------------------------------------
package fpct_pkg;

    localparam int POINTS = 32;
    localparam int PT_AW  = (POINTS > 1) ? $clog2(POINTS) : 1;

    typedef enum logic [1:0] {
        CMD_CHECK = 2'd0,
        CMD_ARM   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOOK = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  point;
        logic [31:0] passes_before_fail;
    } t_in;

    typedef struct packed {
        logic        fail_now;
        logic        point_ok;
        logic [31:0] attempt_count;
        logic [31:0] failure_count;
        logic [31:0] countdown_left;
        logic        is_armed;
    } t_out;

    typedef struct packed {
        logic [31:0] attempts;
        logic [31:0] failures;
        logic [31:0] countdown;
        logic        armed;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[rtl/fpct_ram.sv]
// ---------------------------------------------------------------------------
// fpct_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module fpct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/fpct_update.sv]
// ---------------------------------------------------------------------------
// fpct_update
// Modify stage: applies one command to an entry and forms the result.
// ---------------------------------------------------------------------------
module fpct_update
    import fpct_pkg::*;
(
    input  t_cmd        i_cmd,
    input  logic        i_point_ok,
    input  logic [31:0] i_passes,
    input  t_entry      i_entry,
    output t_entry      o_entry,
    output logic        o_wr_en,
    output t_out        o_result
);

    localparam logic [31:0] MAX32 = '1;

    t_entry w_next;
    logic   w_fail;

    always_comb begin
        w_next  = i_entry;
        w_fail  = 1'b0;
        o_wr_en = 1'b0;
        unique case (i_cmd)
            CMD_CHECK: begin
                o_wr_en = i_point_ok;
                if (i_entry.attempts != MAX32) begin
                    w_next.attempts = i_entry.attempts + 32'd1;
                end
                if (i_entry.armed) begin
                    if (i_entry.countdown != 32'd0) begin
                        w_next.countdown = i_entry.countdown - 32'd1;
                    end else begin
                        w_next.armed = 1'b0;
                        w_fail       = 1'b1;
                        if (i_entry.failures != MAX32) begin
                            w_next.failures = i_entry.failures + 32'd1;
                        end
                    end
                end
            end
            CMD_ARM: begin
                o_wr_en          = i_point_ok;
                w_next.countdown = i_passes;
                w_next.armed     = 1'b1;
            end
            CMD_READ: begin
            end
            CMD_CLEAR: begin
            end
            default: begin
            end
        endcase
    end

    assign o_entry = w_next;

    always_comb begin
        o_result          = '0;
        o_result.point_ok = i_point_ok;
        if (i_point_ok && (i_cmd != CMD_CLEAR)) begin
            o_result.fail_now       = w_fail;
            o_result.attempt_count  = w_next.attempts;
            o_result.failure_count  = w_next.failures;
            o_result.countdown_left = w_next.countdown;
            o_result.is_armed       = w_next.armed;
        end
    end

endmodule

[rtl/fault_point_countdown_table_core.sv]
// ---------------------------------------------------------------------------
// fault_point_countdown_table_core
// Table of fault points held in one RAM; each command reads an entry, check and arm write it back.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-----------------
//  in      | i_in_valid  | o_in_stall  | i_in_data  t_in
//  out     | o_out_valid | i_out_stall | o_out_data t_out
//
// Each transfer in runs as a RAM read, then a modify and write back.
// A result waits in the output register; the next command is taken meanwhile.
// Clear drops all per-entry valid flags at once; unwritten entries read zero.
// Reset clears the valid flags and control; no clearing pass.
// ---------------------------------------------------------------------------
module fault_point_countdown_table_core
    import fpct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_out;
    logic   r_out_valid;
    logic [POINTS-1:0] r_valid;

    logic   w_take, w_commit, w_out_free, w_point_ok, w_wr_en;
    logic [PT_AW-1:0] w_addr;
    t_entry w_rd_data, w_entry, w_new_entry;
    t_out   w_result;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_addr     = r_in.point[PT_AW-1:0];
    assign w_point_ok = ({1'b0, r_in.point} < 9'(POINTS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_LOOK;
            S_LOOK: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_commit   = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_stall = !i_rst_n;
            S_LOOK: w_commit   = w_out_free;
            default: begin
            end
        endcase
    end

    assign w_take = i_in_valid && !o_in_stall;

    fpct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POINTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_commit && w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_new_entry),
        .i_rd_en   (w_take),
        .i_rd_addr (i_in_data.point[PT_AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_entry = r_valid[w_addr] ? w_rd_data : '0;

    fpct_update u_update (
        .i_cmd      (t_cmd'(r_in.cmd)),
        .i_point_ok (w_point_ok),
        .i_passes   (r_in.passes_before_fail),
        .i_entry    (w_entry),
        .o_entry    (w_new_entry),
        .o_wr_en    (w_wr_en),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit) begin
                if (t_cmd'(r_in.cmd) == CMD_CLEAR) begin
                    r_valid <= '0;
                end else if (w_wr_en) begin
                    r_valid[w_addr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in_data;
        end
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
